// ===== src/mcat_pkg.sv =====
// shared types and constants for the multi-channel one-shot alarm timer
package mcat_pkg;

   // timer geometry
   localparam int NUM_CHANNELS = 4;
   localparam int COUNT_WIDTH  = 32;
   localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   // channel that acts as the timeout channel
   localparam logic [1:0] TIMEOUT_CH = 2'd3;

   // prescaler register
   localparam int          PRESCALE_W     = 16;
   localparam logic [15:0] PRESCALE_RESET = 16'd83;

   // register map
   localparam int         CSR_ADDR_W        = 2;
   localparam logic [1:0] CSR_PRESCALE_ADDR = 2'd0;

   // command codes
   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_ARM    = 2'd1,
      CMD_CANCEL = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   // request beat
   typedef struct packed {
      cmd_type     cmd;
      logic [1:0]  channel;
      logic [31:0] offset_us;
   } req_type;

   // response beat
   typedef struct packed {
      logic [3:0]  fired;
      logic [31:0] now_us;
      logic [3:0]  armed_mask;
      logic        timeout_done;
   } rsp_type;

endpackage

// ===== src/mcat_core.sv =====
// timer state and the combinational update for one command beat
module mcat_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   step,
   input  mcat_pkg::req_type                      item,
   input  logic [mcat_pkg::PRESCALE_W-1:0]        prescale,
   output mcat_pkg::rsp_type                      result
);

   localparam int CW = mcat_pkg::COUNT_WIDTH;
   localparam int NC = mcat_pkg::NUM_CHANNELS;

   logic [CW-1:0]                   micro_ff, micro_in;
   logic [mcat_pkg::PRESCALE_W-1:0] presc_ff, presc_in;
   logic [CW-1:0]                   cmp_ff [NC];
   logic [CW-1:0]                   cmp_in [NC];
   logic [NC-1:0]                   armed_ff, armed_in;
   logic                            done_ff, done_in;

   logic [NC-1:0]                   fired;
   logic [CW-1:0]                   micro_inc;
   logic [CW-1:0]                   delay_eff;
   logic [CW-1:0]                   arm_value;
   logic                            ch_ok;
   logic                            is_timeout;
   logic [mcat_pkg::CH_IDX_W-1:0]   ch_idx;

   // operands for tick, arm and cancel
   always_comb begin
      micro_inc  = micro_ff + 1'b1;
      is_timeout = (item.channel == mcat_pkg::TIMEOUT_CH);
      ch_ok      = (32'(item.channel) < NC);
      ch_idx     = mcat_pkg::CH_IDX_W'(item.channel);
      delay_eff  = item.offset_us[CW-1:0];
      if (is_timeout && (delay_eff == '0)) begin
         delay_eff = CW'(1);
      end
      arm_value  = micro_ff + delay_eff;
   end

   // next state for the current command
   always_comb begin
      micro_in = micro_ff;
      presc_in = presc_ff;
      cmp_in   = cmp_ff;
      armed_in = armed_ff;
      done_in  = done_ff;
      fired    = '0;
      case (item.cmd)
         mcat_pkg::CMD_TICK: begin
            if (presc_ff >= prescale) begin
               presc_in = '0;
               micro_in = micro_inc;
               // compare every armed channel against the new count
               for (int c = 0; c < NC; c++) begin
                  if (armed_ff[c] && (cmp_ff[c] == micro_inc)) begin
                     fired[c]    = 1'b1;
                     armed_in[c] = 1'b0;
                     if (c == int'(mcat_pkg::TIMEOUT_CH)) begin
                        done_in = 1'b1;
                     end
                  end
               end
            end else begin
               presc_in = presc_ff + 1'b1;
            end
         end
         mcat_pkg::CMD_ARM: begin
            if (ch_ok) begin
               cmp_in[ch_idx]   = arm_value;
               armed_in[ch_idx] = 1'b1;
               if (is_timeout) begin
                  done_in = 1'b0;
               end
            end
         end
         mcat_pkg::CMD_CANCEL: begin
            if (ch_ok) begin
               armed_in[ch_idx] = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // response fields reflect the state after the command
   always_comb begin
      result.fired        = 4'(fired);
      result.now_us       = 32'(micro_in);
      result.armed_mask   = 4'(armed_in);
      result.timeout_done = done_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         micro_ff <= '0;
         presc_ff <= '0;
         armed_ff <= '0;
         done_ff  <= 1'b0;
      end else if (step) begin
         micro_ff <= micro_in;
         presc_ff <= presc_in;
         armed_ff <= armed_in;
         done_ff  <= done_in;
      end
   end

   // compare values only matter once armed
   always_ff @(posedge clock) begin
      if (step) begin
         cmp_ff <= cmp_in;
      end
   end

endmodule

// ===== src/multi_channel_oneshot_alarm_timer.sv =====
// top level of the multi-channel one-shot alarm timer
//
// Commands arrive on the req_ channel (valid/ready): clock tick, arm, cancel
// or no-op, with a channel number and a delay in microseconds. Every command
// beat yields exactly one rsp_ beat carrying the channels that fired, the
// counter value, the armed mask and the timeout done flag.
// A beat is registered at the input, then applied to the timer state while
// its response is loaded into the response register that drives
// rsp_valid. One beat is taken every cycle while rsp_ready is high, since the
// combinational next state feeds the counter, prescaler and compare
// registers. When the receiver stalls the response register holds its beat,
// the input register still takes one more beat, and req_ready then drops
// until the response is taken.
// The csr_ port holds the prescaler (ticks per microsecond minus one) at
// address 0; write it only while no beat is in flight.
// Reset clears the counter, prescaler, armed channels and done flag, sets
// the prescaler register to 83 and empties both pipeline registers.
module multi_channel_oneshot_alarm_timer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  mcat_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output mcat_pkg::rsp_type                   rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mcat_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   logic                                s1_valid_ff, s1_valid_in;
   mcat_pkg::req_type                   s1_data_ff, s1_data_in;
   logic                                out_valid_ff, out_valid_in;
   mcat_pkg::rsp_type                   out_data_ff, out_data_in;
   logic [mcat_pkg::PRESCALE_W-1:0]     prescale_ff, prescale_in;

   logic                                advance;
   logic                                req_fire;
   logic                                csr_write;
   mcat_pkg::rsp_type                   core_result;

   // handshake control
   assign advance   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   // input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_data;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // timer state and update
   mcat_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .item     (s1_data_ff),
      .prescale (prescale_ff),
      .result   (core_result)
   );

   // response register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = core_result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // prescaler register write
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   always_comb begin
      prescale_in = prescale_ff;
      if (csr_write && (csr_paddr == mcat_pkg::CSR_PRESCALE_ADDR)) begin
         prescale_in = csr_pwdata[mcat_pkg::PRESCALE_W-1:0];
      end
   end

   // register read
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == mcat_pkg::CSR_PRESCALE_ADDR) ? 32'(prescale_ff) : '0;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         prescale_ff  <= mcat_pkg::PRESCALE_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         prescale_ff  <= prescale_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      out_data_ff <= out_data_in;
   end

endmodule

// ===== src/mcat_checker.sv =====
// port-level checks for the alarm timer, bound to the top level
module mcat_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mcat_pkg::rsp_type rsp_data
);

   // a stalled response beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response beat changed");

   // a channel that fires is no longer armed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.fired & rsp_data.armed_mask) == 4'd0))
      else $error("fired channel still armed");

   // timeout channel firing sets the done flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fired[3] |-> rsp_data.timeout_done)
      else $error("timeout fired without done flag");

   // no response right after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind multi_channel_oneshot_alarm_timer mcat_checker u_mcat_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
